// ----- hdl/cer_pkg.sv -----
// ----------------------------------------------------------------------------
// Channel event rate limiter: shared package
// Codes, line record and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package cer_pkg;

  // Input kinds
  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_BEGIN  = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  // Result codes of an emitted line
  localparam logic [2:0] RES_WRITTEN = 3'd0;
  localparam logic [2:0] RES_REFUSED = 3'd1;
  localparam logic [2:0] RES_DROP    = 3'd2;
  localparam logic [2:0] RES_BEGIN   = 3'd3;
  localparam logic [2:0] RES_END     = 3'd4;

  // Channel field of begin and end lines
  localparam logic [2:0] LIFECYCLE_LINE = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_EVENTS_PER_WINDOW = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LENGTH     = 2'd1;
  localparam logic [1:0] CFG_LOGGING_ENABLED   = 2'd2;

  // Configuration reset values
  localparam logic [15:0] EVENTS_PER_WINDOW_RST = 16'd64;
  localparam logic [15:0] WINDOW_LENGTH_RST     = 16'd1000;

  // Lifecycle and refusal lines issued by the controller
  typedef enum logic [1:0] {
    LINE_NONE   = 2'd0,
    LINE_REFUSE = 2'd1,
    LINE_END    = 2'd2,
    LINE_BEGIN  = 2'd3
  } line_op_e;

  // One output line
  typedef struct packed {
    logic [2:0]  res;
    logic [2:0]  chan;
    logic [31:0] session;
    logic [31:0] seq;
    logic [47:0] elapsed;
    logic [31:0] dropped;
  } line_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     scan_step;
    logic     rec_step;
    line_op_e line;
    logic     finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  active;
    logic  log_en;
    logic  scan_last;
    logic  can_load;
  } dp_sts_t;

endpackage

// ----- hdl/cer_ctrl.sv -----
// ----------------------------------------------------------------------------
// Channel event rate limiter: controller
// Sequences one input through window scan, record decision and lifecycle
// lines, then closes the item by releasing the held line with its last flag.
// ----------------------------------------------------------------------------
module cer_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cer_pkg::dp_sts_t  sts_i,
  output cer_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_RECORD,
    ST_END_LINE,
    ST_BEGIN_LINE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  // Next state and commands; once an input is taken, nothing moves while the output cannot take a line
  always_comb begin
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.scan_step = 1'b0;
    cmd_o.rec_step  = 1'b0;
    cmd_o.line      = cer_pkg::LINE_NONE;
    cmd_o.finish    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.can_load) begin
          case (sts_i.kind)
            cer_pkg::KIND_RECORD: begin
              if (!sts_i.active || !sts_i.log_en) begin
                cmd_o.line = cer_pkg::LINE_REFUSE;
                state_d    = ST_FINISH;
              end else begin
                state_d = ST_SCAN;
              end
            end
            cer_pkg::KIND_TICK:  state_d = sts_i.active ? ST_SCAN : ST_FINISH;
            cer_pkg::KIND_BEGIN: state_d = ST_SCAN;
            cer_pkg::KIND_END:   state_d = sts_i.active ? ST_SCAN : ST_FINISH;
            default:             state_d = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.can_load) begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_last) begin
            case (sts_i.kind)
              cer_pkg::KIND_RECORD: state_d = ST_RECORD;
              cer_pkg::KIND_TICK:   state_d = ST_FINISH;
              cer_pkg::KIND_BEGIN:  state_d = sts_i.active ? ST_END_LINE : ST_BEGIN_LINE;
              default:              state_d = ST_END_LINE;
            endcase
          end
        end
      end
      ST_RECORD: begin
        if (sts_i.can_load) begin
          cmd_o.rec_step = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_END_LINE: begin
        if (sts_i.can_load) begin
          cmd_o.line = cer_pkg::LINE_END;
          state_d    = (sts_i.kind == cer_pkg::KIND_BEGIN) ? ST_BEGIN_LINE : ST_FINISH;
        end
      end
      ST_BEGIN_LINE: begin
        if (sts_i.can_load) begin
          cmd_o.line = cer_pkg::LINE_BEGIN;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.can_load) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

// ----- hdl/cer_datapath.sv -----
// ----------------------------------------------------------------------------
// Channel event rate limiter: datapath
// Configuration, session state, per-channel windows, line builder and the
// two-deep line buffer (held line plus output register).
// ----------------------------------------------------------------------------
module cer_datapath #(
  parameter int CHANNELS  = 7,
  parameter int TIME_BITS = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cer_pkg::dp_cmd_t  cmd_i,
  output cer_pkg::dp_sts_t  sts_o,
  // input item
  input  logic [1:0]        kind_i,
  input  logic [2:0]        channel_i,
  input  logic [47:0]       now_ms_i,
  // configuration
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  // result
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        event_res_o,
  output logic [2:0]        line_channel_o,
  output logic [31:0]       session_number_o,
  output logic [31:0]       sequence_number_o,
  output logic [47:0]       elapsed_ms_o,
  output logic [31:0]       dropped_count_o,
  output logic              last_o
);

  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CHANNELS - 1);

  // Configuration
  logic [15:0] epw_q, wl_q;
  logic        log_q;

  // Captured item
  cer_pkg::kind_e         kind_q;
  logic [2:0]             chan_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [IDXW-1:0]        idx_q;

  // Session state
  logic                   active_q;
  logic [31:0]            count_q, seq_q;
  logic [TIME_BITS-1:0]   origin_q, latest_q;

  // Windows
  logic [TIME_BITS-1:0]   win_start_q [CHANNELS];
  logic [15:0]            acc_q       [CHANNELS];
  logic [31:0]            drop_q      [CHANNELS];

  // Line buffer
  cer_pkg::line_t         pend_q, out_q, line;
  logic                   pend_v_q, out_v_q, out_last_q;
  logic                   line_v, line_wr, can_load, out_load;

  // Window read port
  logic [4:0]             chan_ext;
  logic                   chan_ok, force_all, expired, full;
  logic [IDXW-1:0]        rec_idx, rd_idx;
  logic [TIME_BITS-1:0]   sel_start, age;
  logic [15:0]            sel_acc;
  logic [31:0]            sel_drop;

  // Monotonic time for numbered lines
  logic [TIME_BITS-1:0]   gap, el_adv, el_keep, line_el;
  logic                   adv;

  assign chan_ext  = 5'(chan_q);
  assign chan_ok   = (chan_ext < 5'(CHANNELS));
  assign rec_idx   = chan_ok ? IDXW'(chan_q) : '0;
  assign rd_idx    = cmd_i.rec_step ? rec_idx : idx_q;
  assign sel_start = win_start_q[rd_idx];
  assign sel_acc   = acc_q[rd_idx];
  assign sel_drop  = drop_q[rd_idx];

  // Window expiry: serial-number age within [window_length, half range)
  assign force_all = (kind_q == cer_pkg::KIND_BEGIN) || (kind_q == cer_pkg::KIND_END);
  assign age       = now_q - sel_start;
  assign expired   = force_all || ((age >= TIME_BITS'(wl_q)) && !age[TIME_BITS-1]);
  assign full      = (sel_acc >= epw_q);

  // Latest time only moves forward; elapsed picked from two parallel subtracts
  assign gap     = now_q - latest_q;
  assign adv     = (gap != '0) && !gap[TIME_BITS-1];
  assign el_adv  = now_q - origin_q;
  assign el_keep = latest_q - origin_q;
  assign line_el = adv ? el_adv : el_keep;

  // Line builder
  always_comb begin
    line_v       = 1'b0;
    line_wr      = 1'b0;
    line.res     = cer_pkg::RES_REFUSED;
    line.chan    = chan_q;
    line.session = count_q;
    line.seq     = '0;
    line.elapsed = '0;
    line.dropped = '0;
    if (cmd_i.scan_step && expired && active_q && (sel_drop != '0)) begin
      line_v       = 1'b1;
      line_wr      = 1'b1;
      line.res     = cer_pkg::RES_DROP;
      line.chan    = 3'(idx_q);
      line.dropped = sel_drop;
    end
    if (cmd_i.rec_step) begin
      line_v = 1'b1;
      if (chan_ok && !full) begin
        line_wr  = 1'b1;
        line.res = cer_pkg::RES_WRITTEN;
      end
    end
    case (cmd_i.line)
      cer_pkg::LINE_REFUSE: line_v = 1'b1;
      cer_pkg::LINE_END: begin
        line_v    = 1'b1;
        line_wr   = 1'b1;
        line.res  = cer_pkg::RES_END;
        line.chan = cer_pkg::LIFECYCLE_LINE;
      end
      cer_pkg::LINE_BEGIN: begin
        line_v       = 1'b1;
        line.res     = cer_pkg::RES_BEGIN;
        line.chan    = cer_pkg::LIFECYCLE_LINE;
        line.session = count_q + 32'd1;
        line.seq     = 32'd1;
      end
      default: ;
    endcase
    if (line_wr) begin
      line.seq     = seq_q + 32'd1;
      line.elapsed = 48'(line_el);
    end
  end

  // Output register loads from the held line when a newer line or the end arrives
  assign can_load = !out_v_q || out_ready_i;
  assign out_load = pend_v_q && (line_v || cmd_i.finish);

  // Configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epw_q    <= cer_pkg::EVENTS_PER_WINDOW_RST;
      wl_q     <= cer_pkg::WINDOW_LENGTH_RST;
      log_q    <= 1'b1;
      active_q <= 1'b0;
      count_q  <= '0;
      seq_q    <= '0;
      origin_q <= '0;
      latest_q <= '0;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        win_start_q[i] <= '0;
        acc_q[i]       <= '0;
        drop_q[i]      <= '0;
      end
    end else begin
      // register writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          cer_pkg::CFG_EVENTS_PER_WINDOW: epw_q <= cfg_data_i;
          cer_pkg::CFG_WINDOW_LENGTH:     wl_q  <= cfg_data_i;
          cer_pkg::CFG_LOGGING_ENABLED:   log_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      // scan pointer
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.scan_step && (idx_q != LAST_IDX)) begin
        idx_q <= idx_q + 1'b1;
      end
      // window restart
      if (cmd_i.scan_step && expired) begin
        win_start_q[idx_q] <= now_q;
        acc_q[idx_q]       <= '0;
        drop_q[idx_q]      <= '0;
      end
      // record accounting, dropped count saturates
      if (cmd_i.rec_step && chan_ok) begin
        if (full) begin
          if (sel_drop != '1) begin
            drop_q[rec_idx] <= sel_drop + 32'd1;
          end
        end else begin
          acc_q[rec_idx] <= sel_acc + 16'd1;
        end
      end
      // numbered line
      if (line_wr) begin
        seq_q <= seq_q + 32'd1;
        if (adv) begin
          latest_q <= now_q;
        end
      end
      // session lifecycle
      if (cmd_i.line == cer_pkg::LINE_END) begin
        active_q <= 1'b0;
      end
      if (cmd_i.line == cer_pkg::LINE_BEGIN) begin
        active_q <= 1'b1;
        count_q  <= count_q + 32'd1;
        seq_q    <= 32'd1;
        origin_q <= now_q;
        latest_q <= now_q;
      end
      // line buffer occupancy
      if (line_v) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.finish) begin
        pend_v_q <= 1'b0;
      end
      out_v_q <= out_load || (out_v_q && !out_ready_i);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= cer_pkg::kind_e'(kind_i);
      chan_q <= channel_i;
      now_q  <= TIME_BITS'(now_ms_i);
    end
    if (line_v) begin
      pend_q <= line;
    end
    if (out_load) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.finish;
    end
  end

  assign sts_o.kind      = kind_q;
  assign sts_o.active    = active_q;
  assign sts_o.log_en    = log_q;
  assign sts_o.scan_last = (idx_q == LAST_IDX);
  assign sts_o.can_load  = can_load;

  assign out_valid_o       = out_v_q;
  assign event_res_o       = out_q.res;
  assign line_channel_o    = out_q.chan;
  assign session_number_o  = out_q.session;
  assign sequence_number_o = out_q.seq;
  assign elapsed_ms_o      = out_q.elapsed;
  assign dropped_count_o   = out_q.dropped;
  assign last_o            = out_last_q;

endmodule

// ----- hdl/channel_event_rate_limiter_core.sv -----
// ----------------------------------------------------------------------------
// Channel event rate limiter core
// Fixed-window rate limiting of trace records over CHANNELS channels inside
// a session, with drop reports and numbered, time-stamped lines.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o): one transfer per event (record,
//   tick, begin or end) with its channel and millisecond time.
//   Output channel (out_valid_o/out_ready_i): zero to CHANNELS+2 line
//   transfers per event; last_o marks the final line of the event.
//   Config channel (cfg_valid_i/cfg_ready_o): always ready; write only
//   while no event is in flight.
//   The window scan steps one channel per cycle, while the receiver can
//   take a line, through a single window read port.
//   Lines pass through a held slot and an output register, so a new event
//   is taken while the last line of the previous one still waits.
//   A stalled receiver holds the line and pauses the sequencer.
//   Reset clears sessions, windows and the line buffer and loads the default
//   configuration; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module channel_event_rate_limiter_core #(
  parameter int CHANNELS  = 7,
  parameter int TIME_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // events
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  channel_i,
  input  logic [47:0] now_ms_i,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // lines
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [2:0]  line_channel_o,
  output logic [31:0] session_number_o,
  output logic [31:0] sequence_number_o,
  output logic [47:0] elapsed_ms_o,
  output logic [31:0] dropped_count_o,
  output logic        last_o
);

  cer_pkg::dp_cmd_t cmd;
  cer_pkg::dp_sts_t sts;

  // Register writes never stall
  assign cfg_ready_o = 1'b1;

  // Sequencer
  cer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Windows, session state and line buffer
  cer_datapath #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (kind_i),
    .channel_i         (channel_i),
    .now_ms_i          (now_ms_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_res_o       (event_res_o),
    .line_channel_o    (line_channel_o),
    .session_number_o  (session_number_o),
    .sequence_number_o (sequence_number_o),
    .elapsed_ms_o      (elapsed_ms_o),
    .dropped_count_o   (dropped_count_o),
    .last_o            (last_o)
  );

endmodule

// ----- tb/limiter_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rate limiter line predictor
// Keeps its own copy of the session, the windows and the configuration,
// works out the lines that each accepted event must produce, and checks each
// line that leaves the block against the oldest line still due.
// ----------------------------------------------------------------------------
package limiter_tb_pkg;
  import cer_pkg::*;

  localparam int LANES = 7;

  // One predicted line with its end-of-event flag
  typedef struct packed {
    line_t line;
    logic  last;
  } due_line_t;

  class line_predictor;
    // configuration copy
    logic [15:0] per_window;
    logic [15:0] window_len;
    logic        log_on;
    // session and window copy
    bit          active;
    logic [31:0] session_no;
    logic [31:0] line_no;
    logic [47:0] origin_ms;
    logic [47:0] latest_ms;
    logic [47:0] win_start [LANES];
    logic [15:0] win_taken [LANES];
    logic [31:0] win_drops [LANES];

    due_line_t   due_lines [$];
    line_t       fresh [$];
    int          failures;

    function new();
      per_window = EVENTS_PER_WINDOW_RST;
      window_len = WINDOW_LENGTH_RST;
      log_on     = 1'b1;
      active     = 1'b0;
      session_no = '0;
      line_no    = '0;
      origin_ms  = '0;
      latest_ms  = '0;
      failures   = 0;
      for (int i = 0; i < LANES; i++) begin
        win_start[i] = '0;
        win_taken[i] = '0;
        win_drops[i] = '0;
      end
    endfunction

    function int pending();
      return due_lines.size();
    endfunction

    // Register write as seen by the block; unmapped indexes do nothing
    function void write_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_EVENTS_PER_WINDOW: per_window = data;
        CFG_WINDOW_LENGTH:     window_len = data;
        CFG_LOGGING_ENABLED:   log_on = data[0];
        default: ;
      endcase
    endfunction

    function void emit(logic [2:0] res, logic [2:0] chan, logic [31:0] seq,
                       logic [47:0] elapsed, logic [31:0] dropped);
      line_t l;
      l.res     = res;
      l.chan    = chan;
      l.session = session_no;
      l.seq     = seq;
      l.elapsed = elapsed;
      l.dropped = dropped;
      fresh.push_back(l);
    endfunction

    // Numbered line; latest time only moves forward in serial order
    function void numbered_line(logic [2:0] res, logic [2:0] chan,
                                logic [31:0] dropped, logic [47:0] now);
      logic [47:0] d;
      d = now - latest_ms;
      if (d != '0 && !d[47]) latest_ms = now;
      line_no++;
      emit(res, chan, line_no, latest_ms - origin_ms, dropped);
    endfunction

    // Restart expired (or all, when forced) windows, reporting drops
    function void flush_windows(logic [47:0] now, bit forced);
      logic [47:0] d;
      for (int i = 0; i < LANES; i++) begin
        d = now - win_start[i];
        if (forced || (d >= {32'd0, window_len} && !d[47])) begin
          if (win_drops[i] != '0) numbered_line(RES_DROP, 3'(i), win_drops[i], now);
          win_start[i] = now;
          win_taken[i] = '0;
          win_drops[i] = '0;
        end
      end
    endfunction

    // Accepted event: predict its lines and queue them
    function void take_event(kind_e kind, logic [2:0] chan, logic [47:0] now);
      fresh.delete();
      case (kind)
        KIND_RECORD: begin
          if (!active || !log_on) begin
            emit(RES_REFUSED, chan, '0, '0, '0);
          end else begin
            flush_windows(now, 1'b0);
            if (chan >= LANES) begin
              emit(RES_REFUSED, chan, '0, '0, '0);
            end else if (win_taken[chan] >= per_window) begin
              if (win_drops[chan] != '1) win_drops[chan]++;
              emit(RES_REFUSED, chan, '0, '0, '0);
            end else begin
              win_taken[chan]++;
              numbered_line(RES_WRITTEN, chan, '0, now);
            end
          end
        end
        KIND_TICK: begin
          if (active) flush_windows(now, 1'b0);
        end
        KIND_BEGIN: begin
          if (active) begin
            flush_windows(now, 1'b1);
            numbered_line(RES_END, LIFECYCLE_LINE, '0, now);
          end
          session_no++;
          line_no   = '0;
          origin_ms = now;
          latest_ms = now;
          for (int i = 0; i < LANES; i++) begin
            win_start[i] = now;
            win_taken[i] = '0;
            win_drops[i] = '0;
          end
          active = 1'b1;
          numbered_line(RES_BEGIN, LIFECYCLE_LINE, '0, now);
        end
        default: begin
          if (active) begin
            flush_windows(now, 1'b1);
            numbered_line(RES_END, LIFECYCLE_LINE, '0, now);
            active = 1'b0;
          end
        end
      endcase
      for (int i = 0; i < fresh.size(); i++)
        due_lines.push_back('{line: fresh[i], last: (i == fresh.size() - 1)});
    endfunction

    function void match(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        failures++;
      end
    endfunction

    // Line transfer from the block against the oldest line due
    function void check_line(line_t got, logic got_last);
      due_line_t want;
      if (due_lines.size() == 0) begin
        $display("%0t: unexpected line: expected none, actual res %0h chan %0h seq %0h",
                 $time, got.res, got.chan, got.seq);
        failures++;
        return;
      end
      want = due_lines.pop_front();
      match("event_res", want.line.res, got.res);
      match("line_channel", want.line.chan, got.chan);
      match("session_number", want.line.session, got.session);
      match("sequence_number", want.line.seq, got.seq);
      match("elapsed_ms", want.line.elapsed, got.elapsed);
      match("dropped_count", want.line.dropped, got.dropped);
      match("last", want.last, got_last);
    endfunction
  endclass

endpackage

// ----- tb/channel_event_rate_limiter_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Channel event rate limiter core testbench
// Drives record, tick and session events with random idling on both sides,
// predicts every line, and checks each line transfer field by field. Runs
// through several register settings, including the extremes, and one long
// receiver hold-off that backs the block up onto its input.
// ----------------------------------------------------------------------------
module channel_event_rate_limiter_core_test;
  import cer_pkg::*;
  import limiter_tb_pkg::*;

  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          HOLD_CYCLES   = 400;
  localparam logic [1:0]  CFG_UNMAPPED  = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [2:0]  channel_i;
  logic [47:0] now_ms_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  event_res_o;
  logic [2:0]  line_channel_o;
  logic [31:0] session_number_o;
  logic [31:0] sequence_number_o;
  logic [47:0] elapsed_ms_o;
  logic [31:0] dropped_count_o;
  logic        last_o;

  line_t         seen_line;
  line_predictor board;
  bit            calm;      // no idling on either side
  bit            hold_req;  // receiver to hold off for a long stretch
  logic [47:0]   clock_ms;  // running event time
  int unsigned   cycles = 0;

  channel_event_rate_limiter_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .channel_i         (channel_i),
    .now_ms_i          (now_ms_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_res_o       (event_res_o),
    .line_channel_o    (line_channel_o),
    .session_number_o  (session_number_o),
    .sequence_number_o (sequence_number_o),
    .elapsed_ms_o      (elapsed_ms_o),
    .dropped_count_o   (dropped_count_o),
    .last_o            (last_o)
  );

  assign seen_line = {event_res_o, line_channel_o, session_number_o, sequence_number_o,
                      elapsed_ms_o, dropped_count_o};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d lines still due", $time, board.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Line transfers
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_line(seen_line, last_o);
  end

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i = calm || ($urandom_range(0, 99) >= 28);
    end
  end

  // Offer one event and wait for its transfer; called at a falling edge
  task automatic send_event(kind_e kind, logic [2:0] chan, logic [47:0] now);
    if (!calm) begin
      while ($urandom_range(0, 99) < 28) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    kind_i     = kind;
    channel_i  = chan;
    now_ms_i   = now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_event(kind, chan, now);
    @(negedge clk_i);
  endtask

  // Wait until every line has arrived and the block has gone quiet
  task automatic settle();
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(logic [15:0] per_window, logic [15:0] window_len,
                           logic [15:0] log_word);
    settle();
    write_register(CFG_EVENTS_PER_WINDOW, per_window);
    write_register(CFG_WINDOW_LENGTH, window_len);
    write_register(CFG_LOGGING_ENABLED, log_word);
  endtask

  // Mostly well-formed session traffic on a moving clock, some noise
  task automatic random_events(int count, int step);
    kind_e       kind;
    logic [2:0]  chan;
    logic [47:0] now;
    logic [63:0] noise;
    int          roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        noise = {$urandom, $urandom};
        now   = noise[47:0];
        kind  = kind_e'($urandom_range(0, 3));
        chan  = 3'($urandom_range(0, 7));
      end else begin
        // time: small steps, jumps past the window, steps back, repeats
        roll = $urandom_range(0, 99);
        if (roll < 70)      clock_ms = clock_ms + $urandom_range(0, step);
        else if (roll < 85) clock_ms = clock_ms + $urandom_range(step, 8 * step);
        else if (roll < 93) clock_ms = clock_ms - $urandom_range(1, step);
        now  = clock_ms;
        roll = $urandom_range(0, 99);
        if (!board.active) begin
          if (roll < 75)      kind = KIND_BEGIN;
          else if (roll < 90) kind = KIND_RECORD;
          else if (roll < 95) kind = KIND_TICK;
          else                kind = KIND_END;
        end else begin
          if (roll < 72)      kind = KIND_RECORD;
          else if (roll < 85) kind = KIND_TICK;
          else if (roll < 94) kind = KIND_BEGIN;
          else                kind = KIND_END;
        end
        // crowd a few channels so that windows fill up
        roll = $urandom_range(0, 99);
        if (roll < 55)      chan = 3'($urandom_range(0, 2));
        else if (roll < 90) chan = 3'($urandom_range(0, 6));
        else                chan = 3'd7;
      end
      send_event(kind, chan, now);
    end
  endtask

  initial begin
    board       = new();
    calm        = 1'b0;
    hold_req    = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_RECORD;
    channel_i   = '0;
    now_ms_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_EVENTS_PER_WINDOW;
    cfg_data_i  = '0;
    clock_ms    = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset configuration
    send_event(KIND_RECORD, 3'd0, 48'd0);            // record with no session
    send_event(KIND_TICK,   3'd3, 48'd5);            // tick with no session
    send_event(KIND_END,    3'd1, 48'd7);            // end with no session
    send_event(KIND_BEGIN,  3'd0, 48'd100);
    send_event(KIND_RECORD, 3'd0, 48'd100);
    send_event(KIND_RECORD, 3'd7, 48'd150);          // channel out of range
    send_event(KIND_RECORD, 3'd6, 48'd2000);         // all windows expire
    send_event(KIND_RECORD, 3'd3, 48'd1500);         // earlier time
    send_event(KIND_TICK,   3'd0, 48'd3000);
    send_event(KIND_BEGIN,  3'd5, 48'd3500);         // begin inside a session
    send_event(KIND_RECORD, 3'd4, 48'd3600);
    send_event(KIND_END,    3'd2, 48'd4000);
    send_event(KIND_RECORD, 3'd1, 48'd4100);         // after the session closed
    send_event(KIND_BEGIN,  3'd0, 48'hFFFF_FFFF_FFFF);
    send_event(KIND_RECORD, 3'd5, 48'd10);           // time wraps forward
    send_event(KIND_RECORD, 3'd2, 48'h8000_0000_0005); // just under half a turn
    send_event(KIND_RECORD, 3'd2, 48'h0000_0000_0200); // behind the latest time
    send_event(KIND_TICK,   3'd7, 48'h0000_0000_0100);
    send_event(KIND_END,    3'd3, 48'd0);
    send_event(KIND_BEGIN,  3'd7, 48'h7FFF_FFFF_FFF0);
    clock_ms = 48'h7FFF_FFFF_FFF0;

    // Tight limit, short windows
    configure(16'd2, 16'd40, 16'd1);
    random_events(30, 12);

    // Nothing accepted, zero window length: every scan restarts the windows unless time stepped back
    configure(16'd0, 16'd0, 16'hFFFF);
    random_events(25, 5);

    // Widest settings with logging off
    configure(16'hFFFF, 16'hFFFF, 16'hFFFE);
    random_events(25, 30000);

    // Shortest window; receiver holds off while events keep coming
    configure(16'd3, 16'd1, 16'd1);
    write_register(CFG_UNMAPPED, 16'h5A5A);
    hold_req = 1'b1;
    random_events(30, 3);

    // No idling on either side
    configure(16'd1, 16'd100, 16'd1);
    calm = 1'b1;
    random_events(30, 40);
    calm = 1'b0;

    configure(16'd4, 16'd500, 16'd1);
    random_events(20, 150);
    send_event(KIND_END, 3'd0, clock_ms + 48'd1);

    settle();
    if (board.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
